### hdl/uid_membership_table_unit_macros.svh
// assertion macros used by the membership table unit
// no dependencies; included by the module that carries checks
`ifndef UID_MEMBERSHIP_TABLE_UNIT_MACROS_SVH
`define UID_MEMBERSHIP_TABLE_UNIT_MACROS_SVH

// same-cycle implication under synchronous reset
`define UIDM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("uidm: same-cycle check failed");

// next-cycle implication under synchronous reset
`define UIDM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("uidm: next-cycle check failed");

`endif

### hdl/uidm_pkg.sv
// shared constants and types of the membership table
// no dependencies
package uidm_pkg;

   // table geometry defaults
   localparam int SLOTS_DEF     = 32;
   localparam int UID_BYTES_DEF = 4;

   // payload widths
   localparam int CARD_W   = 32;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 5;

   // request modes
   localparam logic MODE_ADD    = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   // value of a used mark
   localparam logic SLOT_TAKEN = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd4;

   // probe status passed from cell to cell
   typedef struct packed {
      logic valid;
      logic hit;
      logic free;
   } uidm_flags_type;

   // slot write command broadcast to all cells
   typedef struct packed {
      logic en;
      logic set;
   } uidm_wr_type;

endpackage

### hdl/uidm_req_if.sv
// request channel: valid/ready handshake with mode and card id
// depends on uidm_pkg
interface uidm_req_if;
   import uidm_pkg::*;

   logic              valid;
   logic              ready;
   logic              mode;
   logic [CARD_W-1:0] card_id;

   modport source (output valid, output mode, output card_id, input ready);
   modport sink (input valid, input mode, input card_id, output ready);
endinterface

### hdl/uidm_rsp_if.sv
// response channel: valid/ready handshake with status and slot index
// depends on uidm_pkg
interface uidm_rsp_if;
   import uidm_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot_index;

   modport source (output valid, output status, output slot_index, input ready);
   modport sink (input valid, input status, input slot_index, output ready);
endinterface

### hdl/uidm_cell.sv
// one table slot: stored id, used mark and one stage of the search probe
// depends on uidm_pkg
module uidm_cell #(
   parameter int ID_W  = 32,
   parameter int IDX_W = 5,
   parameter int INDEX = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  uidm_pkg::uidm_flags_type up_flags,
   input  logic [ID_W-1:0]          up_id,
   input  logic [IDX_W-1:0]         up_hit_idx,
   input  logic [IDX_W-1:0]         up_free_idx,
   output uidm_pkg::uidm_flags_type dn_flags,
   output logic [ID_W-1:0]          dn_id,
   output logic [IDX_W-1:0]         dn_hit_idx,
   output logic [IDX_W-1:0]         dn_free_idx,
   input  uidm_pkg::uidm_wr_type    wr,
   input  logic [IDX_W-1:0]         wr_idx,
   input  logic [ID_W-1:0]          wr_id
);
   import uidm_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic            used_ff, used_in;
   logic [ID_W-1:0] slot_id_ff, slot_id_in;

   uidm_flags_type   probe_flags_ff, probe_flags_in;
   logic [ID_W-1:0]  probe_id_ff;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;

   logic match;
   logic sel;

   // compare against this slot, keep the lowest hit and the highest free slot
   always_comb begin
      match          = (used_ff == SLOT_TAKEN) && (slot_id_ff == up_id);
      probe_flags_in = up_flags;
      hit_idx_in     = up_hit_idx;
      free_idx_in    = up_free_idx;
      if (!up_flags.hit && match) begin
         probe_flags_in.hit = 1'b1;
         hit_idx_in         = MY_IDX;
      end
      if (used_ff != SLOT_TAKEN) begin
         probe_flags_in.free = 1'b1;
         free_idx_in         = MY_IDX;
      end
   end

   // slot update from the broadcast write
   always_comb begin
      sel        = wr.en && (wr_idx == MY_IDX);
      used_in    = used_ff;
      slot_id_in = slot_id_ff;
      if (sel) begin
         used_in    = wr.set ? SLOT_TAKEN : ~SLOT_TAKEN;
         slot_id_in = wr.set ? wr_id : '0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff        <= ~SLOT_TAKEN;
         probe_flags_ff <= '0;
      end else begin
         used_ff        <= used_in;
         probe_flags_ff <= probe_flags_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      slot_id_ff  <= slot_id_in;
      probe_id_ff <= up_id;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
   end

   assign dn_flags    = probe_flags_ff;
   assign dn_id       = probe_id_ff;
   assign dn_hit_idx  = hit_idx_ff;
   assign dn_free_idx = free_idx_ff;

endmodule

### hdl/uid_membership_table_unit.sv
// card id membership table: a chain of SLOTS cells searched by a moving probe
// a request passes through the cell chain, the pending result register and the output register before response valid
// a new request is accepted only in the idle state, after the previous result has been loaded into the output register
// a finished response may wait in the output register while the next request scans
// synchronous reset empties the table and clears all handshake state
module uid_membership_table_unit #(
   parameter int SLOTS     = uidm_pkg::SLOTS_DEF,
   parameter int UID_BYTES = uidm_pkg::UID_BYTES_DEF
) (
   input logic       clock,
   input logic       reset,
   uidm_req_if.sink  req_bus,
   uidm_rsp_if.source rsp_bus
);
   import uidm_pkg::*;
   `include "uid_membership_table_unit_macros.svh"

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int ID_W  = (UID_BYTES >= 4) ? CARD_W : 8 * UID_BYTES;

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       mode_ff, mode_in;

   logic [STATUS_W-1:0] pend_status_ff, pend_status_in;
   logic [SLOT_W-1:0]   pend_slot_ff, pend_slot_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;

   uidm_flags_type   flags_chain [SLOTS+1];
   logic [ID_W-1:0]  id_chain    [SLOTS+1];
   logic [IDX_W-1:0] hit_chain   [SLOTS+1];
   logic [IDX_W-1:0] free_chain  [SLOTS+1];
   logic [SLOTS-1:0] probe_live;

   uidm_wr_type      wr;
   logic [IDX_W-1:0] wr_idx;
   logic             accept;
   logic             load_rsp;
   logic             done_scan;

   logic [STATUS_W-1:0]     res_status;
   logic [IDX_W-1:0]        res_idx;
   logic [IDX_W+SLOT_W-1:0] res_ext;

   assign accept    = req_bus.valid && req_bus.ready;
   assign done_scan = flags_chain[SLOTS].valid;
   assign load_rsp  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   // probe enters the first cell with the request
   assign flags_chain[0] = '{valid: accept, hit: 1'b0, free: 1'b0};
   assign id_chain[0]    = req_bus.card_id[ID_W-1:0];
   assign hit_chain[0]   = '0;
   assign free_chain[0]  = '0;

   // row of slot cells
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      uidm_cell #(
         .ID_W  (ID_W),
         .IDX_W (IDX_W),
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .up_flags    (flags_chain[i]),
         .up_id       (id_chain[i]),
         .up_hit_idx  (hit_chain[i]),
         .up_free_idx (free_chain[i]),
         .dn_flags    (flags_chain[i+1]),
         .dn_id       (id_chain[i+1]),
         .dn_hit_idx  (hit_chain[i+1]),
         .dn_free_idx (free_chain[i+1]),
         .wr          (wr),
         .wr_idx      (wr_idx),
         .wr_id       (id_chain[SLOTS])
      );
      assign probe_live[i] = flags_chain[i+1].valid;
   end

   // decision once the probe leaves the last cell
   always_comb begin
      wr         = '0;
      wr_idx     = hit_chain[SLOTS];
      res_status = ST_ABSENT;
      res_idx    = '0;
      if (mode_ff == MODE_ADD) begin
         if (flags_chain[SLOTS].hit) begin
            res_status = ST_PRESENT;
         end else if (flags_chain[SLOTS].free) begin
            res_status = ST_ADDED;
            res_idx    = free_chain[SLOTS];
            wr_idx     = free_chain[SLOTS];
            wr.en      = done_scan;
            wr.set     = 1'b1;
         end else begin
            res_status = ST_FULL;
         end
      end else begin
         if (flags_chain[SLOTS].hit) begin
            res_status = ST_REMOVED;
            res_idx    = hit_chain[SLOTS];
            wr.en      = done_scan;
            wr.set     = 1'b0;
         end
      end
      res_ext = {{SLOT_W{1'b0}}, res_idx};
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      pend_status_in = pend_status_ff;
      pend_slot_in   = pend_slot_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_SCAN;
               mode_in  = req_bus.mode;
            end
         end
         S_SCAN: begin
            if (done_scan) begin
               state_in       = S_DONE;
               pend_status_in = res_status;
               pend_slot_in   = res_ext[SLOT_W-1:0];
            end
         end
         S_DONE: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = pend_status_ff;
         rsp_slot_in   = pend_slot_ff;
      end else if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      pend_status_ff <= pend_status_in;
      pend_slot_ff   <= pend_slot_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_slot_ff    <= rsp_slot_in;
   end

   assign req_bus.ready      = (state_ff == S_IDLE);
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.slot_index = rsp_slot_ff;

   // checks
   `UIDM_ASSERT_NEXT(a_accept_starts_scan, clock, reset, accept, state_ff == S_SCAN)
   `UIDM_ASSERT_IMPL(a_single_probe, clock, reset, 1'b1, $onehot0(probe_live))
   `UIDM_ASSERT_IMPL(a_probe_only_in_scan, clock, reset, |probe_live, state_ff == S_SCAN)
   `UIDM_ASSERT_NEXT(a_done_delivers, clock, reset, load_rsp, rsp_valid_ff && state_ff == S_IDLE)

endmodule

### sim/uidm_table_checker.sv
`timescale 1ns / 100ps
// checker for the membership table: watches both channels, predicts each response
// from its own copy of the table and compares field by field
// depends on uidm_pkg, uidm_req_if and uidm_rsp_if
module uidm_table_checker #(
   parameter int SLOTS     = uidm_pkg::SLOTS_DEF,
   parameter int UID_BYTES = uidm_pkg::UID_BYTES_DEF
) (
   input  logic clock,
   input  logic reset,
   uidm_req_if  req_mon,
   uidm_rsp_if  rsp_mon,
   output int   mismatch_count,
   output int   outstanding
);
   import uidm_pkg::*;

   // only the low UID_BYTES bytes of an id are stored and compared
   localparam logic [CARD_W-1:0] ID_MASK =
      (UID_BYTES >= 4) ? '1 : CARD_W'((64'd1 << (8 * UID_BYTES)) - 64'd1);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot_index;
   } table_result_type;

   // shadow of the table contents
   logic [CARD_W-1:0] stored_ids [SLOTS];
   logic              slot_used  [SLOTS];

   table_result_type pending_results [$];

   // apply one request to the shadow table and return the response it gives
   function automatic table_result_type predict_membership(input logic mode,
                                                           input logic [CARD_W-1:0] raw_id);
      table_result_type  res;
      logic [CARD_W-1:0] id;
      int                hit;
      int                free_slot;
      id        = raw_id & ID_MASK;
      hit       = -1;
      free_slot = -1;
      // lowest used slot holding the id; unused slots never match
      for (int i = 0; i < SLOTS; i++) begin
         if (hit < 0 && slot_used[i] == SLOT_TAKEN && stored_ids[i] == id) hit = i;
      end
      // highest free slot wins
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_used[i] != SLOT_TAKEN) free_slot = i;
      end
      res.status     = ST_ABSENT;
      res.slot_index = '0;
      if (mode == MODE_ADD) begin
         if (hit >= 0) begin
            res.status = ST_PRESENT;
         end else if (free_slot < 0) begin
            res.status = ST_FULL;
         end else begin
            slot_used[free_slot]  = SLOT_TAKEN;
            stored_ids[free_slot] = id;
            res.status            = ST_ADDED;
            res.slot_index        = SLOT_W'(free_slot);
         end
      end else if (hit >= 0) begin
         slot_used[hit]  = ~SLOT_TAKEN;
         stored_ids[hit] = '0;
         res.status      = ST_REMOVED;
         res.slot_index  = SLOT_W'(hit);
      end
      return res;
   endfunction

   // sample handshakes at the clock edge; responses are popped before new requests
   always @(posedge clock) begin
      table_result_type exp_res;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_used[i]  = ~SLOT_TAKEN;
            stored_ids[i] = '0;
         end
         pending_results.delete();
         mismatch_count <= 0;
         outstanding    <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_results.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected response: status %0d slot %0d",
                           rsp_mon.status, rsp_mon.slot_index);
               mismatch_count <= mismatch_count + 1;
            end else begin
               exp_res = pending_results.pop_front();
               if (rsp_mon.status !== exp_res.status ||
                   rsp_mon.slot_index !== exp_res.slot_index) begin
                  if (mismatch_count < 10)
                     $display("mismatch: expected status %0d slot %0d, got status %0d slot %0d",
                              exp_res.status, exp_res.slot_index,
                              rsp_mon.status, rsp_mon.slot_index);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            pending_results.push_back(predict_membership(req_mon.mode, req_mon.card_id));
         outstanding <= pending_results.size();
      end
   end

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// top of the membership table testbench: clock, reset, request and response
// stimulus with random idling, and the verdict; depends on uidm_pkg, both
// channel interfaces, uid_membership_table_unit and uidm_table_checker
module tb_top;
   import uidm_pkg::*;

   localparam int SLOTS        = SLOTS_DEF;
   localparam int UID_BYTES    = UID_BYTES_DEF;
   localparam int RANDOM_ITEMS = 1000;
   localparam int CALM_ITEMS   = 150;
   localparam int POOL_SIZE    = 48;
   localparam int CYCLE_LIMIT  = 500000;

   logic        clock;
   logic        reset;
   int unsigned cycle_count = 0;
   int          mismatch_count;
   int          outstanding;
   bit          calm = 1'b0;
   int unsigned req_gap_pct = 20;
   int unsigned rsp_stall_pct = 20;

   logic [CARD_W-1:0] id_pool [POOL_SIZE];

   uidm_req_if req_bus ();
   uidm_rsp_if rsp_bus ();

   uid_membership_table_unit #(
      .SLOTS     (SLOTS),
      .UID_BYTES (UID_BYTES)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   uidm_table_checker #(
      .SLOTS     (SLOTS),
      .UID_BYTES (UID_BYTES)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // send one request, with an optional idle burst ahead of it
   task automatic send_request(input logic mode, input logic [CARD_W-1:0] card_id);
      if (!calm && $urandom_range(0, 99) < req_gap_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.mode    <= mode;
      req_bus.card_id <= card_id;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // mostly ids from a shared pool so that hits, duplicates and a full table occur
   function automatic logic [CARD_W-1:0] pick_id();
      if ($urandom_range(0, 9) == 0) return $urandom;
      return id_pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   // response side back-pressure
   initial begin
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // reset, stimulus and verdict
   initial begin
      int sent;
      int phase;
      int len;
      int add_pct;
      int kind;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.mode    = MODE_ADD;
      req_bus.card_id = '0;
      id_pool[0] = '0;
      id_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = $urandom;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, extreme ids, duplicate, highest free slot reuse,
      // cleared slot holding zero must not match, then empty the table again
      send_request(MODE_REMOVE, 32'h0000_0000);
      send_request(MODE_ADD,    32'h0000_0000);
      send_request(MODE_ADD,    32'hFFFF_FFFF);
      send_request(MODE_ADD,    32'h0000_0000);
      send_request(MODE_ADD,    32'hA5A5_A5A5);
      send_request(MODE_REMOVE, 32'hFFFF_FFFF);
      send_request(MODE_REMOVE, 32'hFFFF_FFFF);
      send_request(MODE_ADD,    32'h5A5A_5A5A);
      send_request(MODE_REMOVE, 32'h0000_0000);
      send_request(MODE_REMOVE, 32'h0000_0000);
      send_request(MODE_ADD,    32'h8000_0000);
      send_request(MODE_ADD,    32'h0000_0001);
      send_request(MODE_ADD,    32'h8000_0000);
      send_request(MODE_REMOVE, 32'h5A5A_5A5A);
      send_request(MODE_REMOVE, 32'hA5A5_A5A5);
      send_request(MODE_REMOVE, 32'h8000_0000);
      send_request(MODE_REMOVE, 32'h0000_0001);
      send_request(MODE_REMOVE, 32'h7FFF_FFFE);

      // random phases: fill-heavy, drain-heavy and mixed; the first one fills
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         len  = $urandom_range(20, 80);
         kind = (phase == 0) ? 0 : $urandom_range(0, 2);
         case (kind)
            0: add_pct = 85;
            1: add_pct = 15;
            default: add_pct = 50;
         endcase
         req_gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
         rsp_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
         for (int k = 0; k < len && sent < RANDOM_ITEMS; k++) begin
            if (sent >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
            send_request(($urandom_range(0, 99) < add_pct) ? MODE_ADD : MODE_REMOVE,
                         pick_id());
            sent++;
         end
         phase++;
      end
      req_bus.valid <= 1'b0;

      // let the last request reach the checker's count, drain, then allow for
      // one more pass of the cell chain
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SLOTS + 8) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
